/* rtl/gte_pkg.sv */
// ----------------------------------------------------------------------------
// gte_pkg: shared types and constants for the gregorian to ethiopian converter
// Field widths, month codes, calendar correction tables and the result record.
// ----------------------------------------------------------------------------
package gte_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;

  // gregorian month codes used by the conversion
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // ethiopian month codes
  localparam logic [MONTH_W-1:0] ETH_MESKEREM = 4'd1;
  localparam logic [MONTH_W-1:0] ETH_NEHASE   = 4'd12;
  localparam logic [MONTH_W-1:0] ETH_PAGUME   = 4'd13;

  localparam logic [YEAR_W-1:0] MIN_YEAR = 14'd8;

  typedef struct packed {
    logic               date_ok;
    logic [DAY_W-1:0]   eth_day;
    logic [MONTH_W-1:0] eth_month;
    logic [YEAR_W-1:0]  eth_year;
  } gte_res_t;

  // days in a gregorian month, february without the leap day
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:                      month_len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  // day correction, year mod 4 == 0
  function automatic logic signed [3:0] hc_leap(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2, 4'd4, 4'd5:   hc_leap = 4'sd1;
      4'd6, 4'd7:         hc_leap = 4'sd2;
      4'd8:               hc_leap = 4'sd3;
      4'd9, 4'd10:        hc_leap = 4'sd4;
      4'd11, 4'd12:       hc_leap = 4'sd5;
      default:            hc_leap = 4'sd0;
    endcase
  endfunction

  // day correction, other years
  function automatic logic signed [3:0] hc_other(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:               hc_other = 4'sd1;
      4'd3:               hc_other = -4'sd1;
      4'd6, 4'd7:         hc_other = 4'sd1;
      4'd8:               hc_other = 4'sd2;
      4'd9, 4'd10:        hc_other = 4'sd3;
      4'd11, 4'd12:       hc_other = 4'sd4;
      default:            hc_other = 4'sd0;
    endcase
  endfunction

  // month correction, year mod 4 == 0
  function automatic logic [2:0] rc_leap(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd3, 4'd11, 4'd12: rc_leap = 3'd4;
      4'd2, 4'd4, 4'd5:         rc_leap = 3'd3;
      4'd6, 4'd7:               rc_leap = 3'd2;
      4'd8:                     rc_leap = 3'd1;
      4'd9, 4'd10:              rc_leap = 3'd5;
      default:                  rc_leap = 3'd0;
    endcase
  endfunction

  // month correction, year mod 4 == 3
  function automatic logic [2:0] rc_three(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd4, 4'd5:         rc_three = 3'd3;
      4'd2, 4'd6, 4'd7:         rc_three = 3'd2;
      4'd3:                     rc_three = 3'd4;
      4'd8:                     rc_three = 3'd1;
      4'd9, 4'd10:              rc_three = 3'd6;
      4'd11, 4'd12:             rc_three = 3'd5;
      default:                  rc_three = 3'd0;
    endcase
  endfunction

  // month correction, year mod 4 == 1 or 2
  function automatic logic [2:0] rc_onetwo(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd4, 4'd5:         rc_onetwo = 3'd3;
      4'd2, 4'd6, 4'd7:         rc_onetwo = 3'd2;
      4'd3, 4'd11, 4'd12:       rc_onetwo = 3'd4;
      4'd8:                     rc_onetwo = 3'd1;
      4'd9, 4'd10:              rc_onetwo = 3'd5;
      default:                  rc_onetwo = 3'd0;
    endcase
  endfunction

endpackage

/* rtl/gte_conv.sv */
// ----------------------------------------------------------------------------
// gte_conv: date check and calendar mapping
// Validates a gregorian date and maps it to ethiopian day, month and year.
// ----------------------------------------------------------------------------
module gte_conv (
  input  logic [gte_pkg::DAY_W-1:0]   greg_day,
  input  logic [gte_pkg::MONTH_W-1:0] greg_month,
  input  logic [gte_pkg::YEAR_W-1:0]  greg_year,
  output gte_pkg::gte_res_t           res
);

  logic                          leap;
  logic                          three;
  logic                          fields_ok;
  logic [gte_pkg::DAY_W-1:0]     lim;
  logic                          ok;
  logic signed [3:0]             hc;
  logic [2:0]                    rc;
  logic [3:0]                    offs;
  logic [8:0]                    thr;
  logic [3:0]                    adj;
  logic [3:0]                    nyd;
  logic [8:0]                    mon30;
  logic [10:0]                   s;
  logic                          over;
  logic signed [6:0]             t;
  logic signed [6:0]             t30;
  logic [gte_pkg::DAY_W-1:0]     dd;
  logic [4:0]                    m_raw;
  logic [4:0]                    m12;
  logic [gte_pkg::MONTH_W-1:0]   mm;
  logic                          is_sep;
  logic                          past_nyd;
  logic [gte_pkg::YEAR_W-1:0]    yy;

  assign leap  = (greg_year[1:0] == 2'd0);
  assign three = (greg_year[1:0] == 2'd3);

  assign fields_ok = (greg_day != '0) && (greg_month >= gte_pkg::MON_JAN) &&
                     (greg_month <= gte_pkg::MON_DEC) && (greg_year >= gte_pkg::MIN_YEAR);
  assign lim = (greg_month == gte_pkg::MON_FEB && leap) ? 5'd29 :
               gte_pkg::month_len(greg_month);
  assign ok  = fields_ok && (greg_day <= lim);

  assign hc   = leap ? gte_pkg::hc_leap(greg_month) : gte_pkg::hc_other(greg_month);
  assign rc   = leap  ? gte_pkg::rc_leap(greg_month) :
                three ? gte_pkg::rc_three(greg_month) : gte_pkg::rc_onetwo(greg_month);
  assign offs = leap  ? 4'd9 : 4'd8;
  assign thr  = three ? 9'd276 : 9'd275;
  assign adj  = three ? 4'd6 : 4'd5;
  assign nyd  = three ? 4'd12 : 4'd11;

  // running day count, only needed for the threshold test
  assign mon30 = {greg_month, 5'b0} - {4'b0, greg_month, 1'b0};
  assign s     = 11'(greg_day) + 11'(mon30) + 11'(hc) - 11'(offs);
  assign over  = (s > 11'(thr));

  // s mod 30 taken on the part below the month multiple: range -15..28
  assign t   = $signed({2'b00, greg_day}) + 7'(hc) - $signed({3'b000, offs})
               - (over ? $signed({3'b000, adj}) : 7'sd0);
  assign t30 = t + 7'sd30;
  assign dd  = (t > 7'sd0) ? t[4:0] : t30[4:0];

  assign m_raw = 5'(greg_month) + ((greg_day > 5'({1'b0, rc} + 4'd5)) ? 5'd4 : 5'd3);
  assign m12   = (m_raw >= 5'd12) ? m_raw - 5'd12 : m_raw;

  assign is_sep   = (greg_month == gte_pkg::MON_SEP);
  assign past_nyd = (greg_day >= 5'(nyd));

  always_comb begin
    if (m12 != 5'd0) begin
      mm = m12[3:0];
    end else if (is_sep && past_nyd) begin
      mm = gte_pkg::ETH_MESKEREM;
    end else if (is_sep && greg_day >= 5'd6) begin
      mm = gte_pkg::ETH_PAGUME;
    end else begin
      mm = gte_pkg::ETH_NEHASE;
    end
  end

  assign yy = ((greg_month > gte_pkg::MON_SEP) || (is_sep && past_nyd)) ?
              greg_year - 14'd7 : greg_year - 14'd8;

  always_comb begin
    res = '0;
    if (ok) begin
      res.date_ok   = 1'b1;
      res.eth_day   = dd;
      res.eth_month = mm;
      res.eth_year  = yy;
    end
  end

endmodule

/* rtl/gregorian_to_ethiopian_date_top.sv */
// ----------------------------------------------------------------------------
// gregorian_to_ethiopian_date_top: gregorian to ethiopian date converter
// Two-register stream pipeline around the combinational date mapping.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one gregorian date per request; in_tdata holds greg_day,
//   greg_month and greg_year. out_* returns one result per request: the
//   ethiopian day, month and year in out_tdata and the validity flag in
//   out_tuser. An invalid date comes back with the flag and all fields zero.
//   A request accepted into the input register moves through the mapping into
//   the result register, which drives out_tvalid, once that register is free.
//   Throughput is one date per cycle while out_tready stays high, set by the
//   single result register that the input register drains into.
//   A synchronous active-low reset empties both registers; no request is in
//   flight afterwards and in_tready is high.
//   When the receiver holds out_tready low, the result stays put, the input
//   register still takes one more request, and in_tready then drops until
//   the result is taken.
// ----------------------------------------------------------------------------
module gregorian_to_ethiopian_date_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // greg_day[4:0], greg_month[8:5], greg_year[22:9], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // eth_day[4:0], eth_month[8:5], eth_year[22:9], pad
  output logic        out_tuser   // date_ok
);

  logic                          in_valid_r;
  logic [gte_pkg::DAY_W-1:0]     day_r;
  logic [gte_pkg::MONTH_W-1:0]   month_r;
  logic [gte_pkg::YEAR_W-1:0]    year_r;
  logic                          out_valid_r;
  gte_pkg::gte_res_t             res_r;
  gte_pkg::gte_res_t             res_nxt;
  logic                          out_free;
  logic                          in_take;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      day_r   <= in_tdata[4:0];
      month_r <= in_tdata[8:5];
      year_r  <= in_tdata[22:9];
    end
  end

  gte_conv u_conv (
    .greg_day   (day_r),
    .greg_month (month_r),
    .greg_year  (year_r),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.date_ok;
  assign out_tdata  = {1'b0, res_r.eth_year, res_r.eth_month, res_r.eth_day};

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !in_valid_r)
    else $error("pipeline not empty after reset");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_free |=> out_valid_r)
    else $error("held request did not reach the result register");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.date_ok |-> res_r.eth_day == '0 && res_r.eth_month == '0 &&
    res_r.eth_year == '0)
    else $error("invalid date with nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.date_ok |-> res_r.eth_day != '0 && res_r.eth_day <= 5'd30 &&
    res_r.eth_month != '0 && res_r.eth_month <= gte_pkg::ETH_PAGUME)
    else $error("ethiopian day or month out of range");
`endif

endmodule
